// File: hw/rtl/ffea_pkg.sv
package ffea_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] file_key;
    logic [15:0] alloc_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_start;
    logic [7:0]  entry_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] start;
    logic [15:0] length;
  } entry_t;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_FORMAT = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [15:0] CAPACITY_RESET = 16'd1000;

endpackage

// File: hw/rtl/ffea_cell.sv
module ffea_cell (
  input  logic             clk,
  input  logic             shift,
  input  ffea_pkg::entry_t d,
  output ffea_pkg::entry_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: hw/rtl/first_fit_extent_allocator.sv
// Channel   Direction  Handshake              Beat
// req       in         req_valid / req_stall  action, file_key, alloc_length
// rsp       out        rsp_valid / rsp_stall  status, alloc_start, entry_total
// cfg       in         cfg_we                 cfg_wdata = space_capacity
//
// Create and delete rotate the table once through the chain of cells, one entry per
// cycle past the head, where the search, insert or removal is done. Format, an unused
// action and a create on a full table skip the pass and go straight to the result.
// A new beat is accepted while a result still waits on rsp. Reset leaves an empty table
// and a capacity of 1000; there is no clearing pass. A stalled result holds the next
// result in its finish state until the beat is taken.
module first_fit_extent_allocator #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffea_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ffea_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PASS   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state;
  logic [IW-1:0]    t;
  logic [CW-1:0]    count;
  logic [15:0]      capacity;
  ffea_pkg::req_t   cur;
  logic [16:0]      pos;
  logic             found;
  logic             ins;
  logic             matched;
  ffea_pkg::entry_t hold;
  logic [1:0]       res_status;
  logic [15:0]      res_start;

  logic [16:0]      pos_next;
  logic             found_next;
  logic             ins_next;
  logic             matched_next;
  ffea_pkg::entry_t hold_next;
  logic [15:0]      start_next;

  ffea_pkg::entry_t cell_q [MAX_ENTRIES];
  ffea_pkg::entry_t tail;
  ffea_pkg::entry_t head;
  ffea_pkg::entry_t nxt;
  ffea_pkg::entry_t new_ent;
  logic             live;
  logic [17:0]      need;
  logic             last;

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      if (k == MAX_ENTRIES - 1) begin : g_tail
        ffea_cell u_cell (.clk(clk), .shift(state == S_PASS), .d(tail), .q(cell_q[k]));
      end else begin : g_mid
        ffea_cell u_cell (.clk(clk), .shift(state == S_PASS), .d(cell_q[k+1]),
                          .q(cell_q[k]));
      end
    end
  endgenerate

  assign head      = cell_q[0];
  assign nxt       = cell_q[1];
  assign live      = CW'(t) < count;
  assign need      = 18'(pos) + 18'(cur.alloc_length);
  assign last      = t == IW'(MAX_ENTRIES - 1);
  assign req_stall = state != S_IDLE;

  always_comb begin
    new_ent.key    = cur.file_key;
    new_ent.start  = pos[15:0];
    new_ent.length = cur.alloc_length;
    tail         = head;
    pos_next     = pos;
    found_next   = found;
    ins_next     = ins;
    matched_next = matched;
    hold_next    = hold;
    start_next   = res_start;
    case (cur.action)
      ffea_pkg::ACT_CREATE: begin
        if (ins) begin
          tail      = hold;
          hold_next = head;
        end else if (!found) begin
          if (!live || 18'(head.start) >= need) begin
            found_next = 1'b1;
            if (need <= 18'(capacity)) begin
              tail       = new_ent;
              ins_next   = 1'b1;
              hold_next  = head;
              start_next = pos[15:0];
            end
          end else begin
            pos_next = 17'(head.start) + 17'(head.length);
          end
        end
      end
      ffea_pkg::ACT_DELETE: begin
        if (matched) begin
          tail = nxt;
        end else if (live && head.key == cur.file_key) begin
          matched_next = 1'b1;
          tail         = nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      t         <= '0;
      count     <= '0;
      capacity  <= ffea_pkg::CAPACITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (rsp_valid && !rsp_stall && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur        <= req;
            t          <= '0;
            pos        <= '0;
            found      <= 1'b0;
            ins        <= 1'b0;
            matched    <= 1'b0;
            res_start  <= '0;
            res_status <= ffea_pkg::STAT_OK;
            case (req.action)
              ffea_pkg::ACT_CREATE: begin
                if (count >= CW'(MAX_ENTRIES)) begin
                  res_status <= ffea_pkg::STAT_FULL;
                  state      <= S_FINISH;
                end else begin
                  state <= S_PASS;
                end
              end
              ffea_pkg::ACT_DELETE: begin
                state <= S_PASS;
              end
              ffea_pkg::ACT_FORMAT: begin
                count <= '0;
                state <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_PASS: begin
          pos       <= pos_next;
          found     <= found_next;
          ins       <= ins_next;
          matched   <= matched_next;
          hold      <= hold_next;
          res_start <= start_next;
          if (last) begin
            t     <= '0;
            state <= S_FINISH;
            if (cur.action == ffea_pkg::ACT_CREATE) begin
              if (ins_next) begin
                count <= count + CW'(1);
              end else begin
                res_status <= ffea_pkg::STAT_NO_SPACE;
              end
            end else begin
              if (matched_next) begin
                count <= count - CW'(1);
              end else begin
                res_status <= ffea_pkg::STAT_NOT_FOUND;
              end
            end
          end else begin
            t <= t + IW'(1);
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status      <= res_status;
            rsp.alloc_start <= res_start;
            rsp.entry_total <= 8'(count);
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("extent count exceeds table size");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    state != S_PASS |-> t == '0)
    else $error("rotation index not at zero outside a pass");

  a_fit: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && cur.action == ffea_pkg::ACT_CREATE &&
    res_status == ffea_pkg::STAT_OK |->
    18'(res_start) + 18'(cur.alloc_length) <= 18'(capacity))
    else $error("created extent runs past capacity");

  a_pass_len: assert property (@(posedge clk) disable iff (rst)
    state == S_PASS && last |=> state == S_FINISH)
    else $error("pass did not end after a full rotation");
`endif

endmodule
